FILE: sv/assert_macros.svh
// Assertion macros for the checker file of the ordered list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock edge, switched off while reset is held.
`define BOL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Concurrent assertion that also holds during reset.
`define BOL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bol_pkg.sv
// Package with the shared types and constants of the bounded ordered list.
package bol_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int POS_W          = 5;
    localparam int WORD_W         = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_SEARCH  = 3'd2,
        OP_SELECT  = 3'd3,
        OP_REPLACE = 3'd4
    } op_code_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_WRITE  = 3'd3,
        CELL_ROTATE = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     head_is_left;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } ctrl_state_t;

endpackage

FILE: sv/bounded_ordered_list.sv
// Top level of the bounded ordered list: controller and a chain of DEPTH entry cells.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   s_operation, s_position, s_data_word
//   m_       out        m_valid / m_ready   m_ok, m_found_position, m_read_word, m_entry_count
//
// Insert, remove, replace and unknown codes need no scan: every cell shifts or writes at once.
// Search and select scan first: the chain rotates one full turn past cell 0, where the
// single comparator and read tap sit, and the result is registered at the end of the turn.
// The result lands in an output register; a new item is taken once no scan runs and that register is
// free or being emptied. Reset (aresetn low, synchronous) empties the list and the output.
module bounded_ordered_list import bol_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [POS_W-1:0]  s_position,
    input  logic [WORD_W-1:0] s_data_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [POS_W-1:0]  m_found_position,
    output logic [WORD_W-1:0] m_read_word,
    output logic [POS_W-1:0]  m_entry_count
);

    localparam int IDX_W = $clog2(DEPTH);

    cell_cmd_t             cell_cmd;
    cell_cmd_t             head_cmd;
    logic [IDX_W-1:0]      cell_pos;
    logic [DATA_WIDTH-1:0] cell_word;
    logic [DATA_WIDTH-1:0] chain_word [DEPTH];

    always_comb begin
        head_cmd              = cell_cmd;
        head_cmd.head_is_left = 1'b0;
    end

    bol_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_position       (s_position),
        .s_data_word      (s_data_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_found_position (m_found_position),
        .m_read_word      (m_read_word),
        .m_entry_count    (m_entry_count),
        .head_word        (chain_word[0]),
        .cell_cmd         (cell_cmd),
        .cell_pos         (cell_pos),
        .cell_word        (cell_word)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        ((i == 0) ? head_cmd : cell_cmd),
            .cmd_pos    (cell_pos),
            .cmd_word   (cell_word),
            .left_word  (chain_word[(i == 0) ? 0 : i - 1]),
            .right_word (chain_word[(i == DEPTH - 1) ? 0 : i + 1]),
            .entry_word (chain_word[i])
        );
    end

endmodule

FILE: sv/bol_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
module bol_cell import bol_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(DEPTH_DEF),
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  cell_cmd_t             cmd,
    input  logic [IDX_W-1:0]      cmd_pos,
    input  logic [DATA_WIDTH-1:0] cmd_word,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    output logic [DATA_WIDTH-1:0] entry_word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic [DATA_WIDTH-1:0] upper_word;

    // The first cell has no left neighbor; it never takes one on insert.
    assign upper_word = cmd.head_is_left ? left_word : cmd_word;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (MY_IDX > cmd_pos) begin
                    entry_next = upper_word;
                end else if (MY_IDX == cmd_pos) begin
                    entry_next = cmd_word;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= cmd_pos) begin
                    entry_next = right_word;
                end
            end
            CELL_WRITE: begin
                if (MY_IDX == cmd_pos) begin
                    entry_next = cmd_word;
                end
            end
            CELL_ROTATE: begin
                entry_next = right_word;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_word = entry_reg;

endmodule

FILE: sv/bol_ctrl.sv
// Controller of the list: handshakes, entry count, chain commands, scan and result register.
module bol_ctrl import bol_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [POS_W-1:0]      s_position,
    input  logic [WORD_W-1:0]     s_data_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [POS_W-1:0]      m_found_position,
    output logic [WORD_W-1:0]     m_read_word,
    output logic [POS_W-1:0]      m_entry_count,
    input  logic [DATA_WIDTH-1:0] head_word,
    output cell_cmd_t             cell_cmd,
    output logic [IDX_W-1:0]      cell_pos,
    output logic [DATA_WIDTH-1:0] cell_word
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    ctrl_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  scan_search_reg, scan_search_next;
    logic [DATA_WIDTH-1:0] scan_word_reg, scan_word_next;
    logic [IDX_W-1:0]      scan_target_reg, scan_target_next;
    logic                  scan_empty_reg, scan_empty_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      found_pos_reg, found_pos_next;
    logic [DATA_WIDTH-1:0] sel_word_reg, sel_word_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_ok_reg, m_ok_next;
    logic [POS_W-1:0]      m_found_reg, m_found_next;
    logic [WORD_W-1:0]     m_read_reg, m_read_next;
    logic [POS_W-1:0]      m_count_reg, m_count_next;

    logic                  accept;
    logic                  load_out;
    logic                  out_ok;
    logic [CNT_W-1:0]      out_found;
    logic [DATA_WIDTH-1:0] out_read;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  pos_in_range;
    logic [DATA_WIDTH-1:0] in_word;
    logic [CNT_W-1:0]      scan_idx_ext;
    op_code_t              op;

    assign s_ready      = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept       = s_valid && s_ready;
    assign op           = op_code_t'(s_operation);
    assign pos_ext      = CMP_W'(s_position);
    assign cnt_ext      = CMP_W'(count_reg);
    assign pos_in_range = pos_ext < cnt_ext;
    assign in_word      = DATA_WIDTH'(s_data_word);
    assign scan_idx_ext = CNT_W'(scan_idx_reg);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        scan_search_next = scan_search_reg;
        scan_word_next   = scan_word_reg;
        scan_target_next = scan_target_reg;
        scan_empty_next  = scan_empty_reg;
        found_next       = found_reg;
        found_pos_next   = found_pos_reg;
        sel_word_next    = sel_word_reg;
        cell_cmd.op           = CELL_HOLD;
        cell_cmd.head_is_left = 1'b1;
        cell_pos         = IDX_W'(s_position);
        cell_word        = in_word;
        load_out         = 1'b0;
        out_ok           = 1'b0;
        out_found        = '0;
        out_read         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_INSERT: begin
                            load_out = 1'b1;
                            if ((cnt_ext < CMP_W'(DEPTH)) && (pos_ext <= cnt_ext)) begin
                                out_ok      = 1'b1;
                                cell_cmd.op = CELL_INSERT;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            load_out = 1'b1;
                            if (pos_in_range) begin
                                out_ok      = 1'b1;
                                cell_cmd.op = CELL_REMOVE;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        OP_REPLACE: begin
                            load_out = 1'b1;
                            if (pos_in_range) begin
                                out_ok      = 1'b1;
                                cell_cmd.op = CELL_WRITE;
                            end
                        end
                        OP_SEARCH, OP_SELECT: begin
                            state_next       = ST_SCAN;
                            scan_idx_next    = '0;
                            scan_search_next = (op == OP_SEARCH);
                            scan_word_next   = in_word;
                            scan_target_next = pos_in_range ? IDX_W'(s_position)
                                                            : IDX_W'(count_reg - 1'b1);
                            scan_empty_next  = (count_reg == '0);
                            found_next       = 1'b0;
                            found_pos_next   = count_reg;
                            sel_word_next    = '0;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // The chain turns once; cell 0 shows the entry at scan_idx_reg.
                cell_cmd.op   = CELL_ROTATE;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_search_reg && !found_reg && (scan_idx_ext < count_reg)
                        && (head_word == scan_word_reg)) begin
                    found_next     = 1'b1;
                    found_pos_next = scan_idx_ext;
                end
                if (!scan_search_reg && !scan_empty_reg
                        && (scan_idx_reg == scan_target_reg)) begin
                    sel_word_next = head_word;
                end
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                    load_out   = 1'b1;
                    out_ok     = 1'b1;
                    out_found  = scan_search_reg ? found_pos_next : '0;
                    out_read   = scan_search_reg ? '0 : sel_word_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_found_next = m_found_reg;
        m_read_next  = m_read_reg;
        m_count_next = m_count_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_ok_next    = out_ok;
            m_found_next = POS_W'(out_found);
            m_read_next  = WORD_W'(out_read);
            m_count_next = POS_W'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg    <= scan_idx_next;
        scan_search_reg <= scan_search_next;
        scan_word_reg   <= scan_word_next;
        scan_target_reg <= scan_target_next;
        scan_empty_reg  <= scan_empty_next;
        found_reg       <= found_next;
        found_pos_reg   <= found_pos_next;
        sel_word_reg    <= sel_word_next;
        m_ok_reg        <= m_ok_next;
        m_found_reg     <= m_found_next;
        m_read_reg      <= m_read_next;
        m_count_reg     <= m_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = m_ok_reg;
    assign m_found_position = m_found_reg;
    assign m_read_word      = m_read_reg;
    assign m_entry_count    = m_count_reg;

endmodule

FILE: sv/bol_checker.sv
// Port-level checker for the bounded ordered list and its bind to the top level.
`include "assert_macros.svh"

module bol_checker import bol_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_ok,
    input logic [POS_W-1:0]  m_found_position,
    input logic [WORD_W-1:0] m_read_word,
    input logic [POS_W-1:0]  m_entry_count
);

    property p_reset_empties_output;
        !aresetn |=> !m_valid;
    endproperty

    property p_result_held;
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_entry_count)
            && $stable(m_read_word) && $stable(m_found_position);
    endproperty

    property p_one_item_in_flight;
        s_valid && s_ready |=> m_valid || !s_ready;
    endproperty

    property p_lookup_fields_need_ok;
        m_valid && (m_found_position != '0 || m_read_word != '0) |-> m_ok;
    endproperty

    `BOL_ASSERT_ALWAYS(a_reset_empties_output, aclk, p_reset_empties_output, "Result item seen after reset.")

    `BOL_ASSERT(a_result_held, aclk, aresetn, p_result_held, "Stalled result item changed.")

    `BOL_ASSERT(a_one_item_in_flight, aclk, aresetn, p_one_item_in_flight, "New item taken early.")

    `BOL_ASSERT(a_lookup_fields_need_ok, aclk, aresetn, p_lookup_fields_need_ok, "Bad lookup item.")

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (.*);
